// ===== hdl/hara_pkg.sv =====
package hara_pkg;

   localparam int ACOS_TABLE_DEPTH = 1024;
   localparam int IDX_W = $clog2(ACOS_TABLE_DEPTH + 1);
   localparam int CORDIC_STEPS = 17;
   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS = 16;
   localparam logic [15:0] PI_Q14 = 16'd51472;
   localparam logic [15:0] HALF_PI_Q14 = 16'd25736;
   localparam logic [15:0] COS_ONE_Q14 = 16'd16384;

   typedef logic [15:0] acos_rom_type [0:ACOS_TABLE_DEPTH];
   typedef longint atan_tab_type [0:CORDIC_STEPS-1];

   localparam atan_tab_type ATAN_Q16 = '{
      51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
      128, 64, 32, 16, 8, 4, 2, 1
   };

   typedef struct packed {
      logic        ok;
      logic        neg;
      logic [15:0] dip;
      logic [34:0] ad;
      logic [5:0]  nsh;
   } side_type;

   // Builds acos(i / depth) in Q14 with a vectoring CORDIC in Q16.
   function automatic acos_rom_type acos_rom_build();
      acos_rom_type tab;
      longint unsigned ux, vv, rr, bb;
      longint x, y, z, dx, dy;
      for (int i = 0; i <= ACOS_TABLE_DEPTH; i++) begin
         ux = (longint'(i) << 30) / ACOS_TABLE_DEPTH;
         vv = (64'd1 << 60) - ux * ux;
         rr = 0;
         bb = 64'd1 << 62;
         while (bb > vv) bb = bb >> 2;
         while (bb != 0) begin
            if (vv >= rr + bb) begin
               vv = vv - (rr + bb);
               rr = (rr >> 1) + bb;
            end else begin
               rr = rr >> 1;
            end
            bb = bb >> 2;
         end
         x = longint'(ux);
         y = longint'(rr);
         z = 0;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
               x = x + dx;
               y = y - dy;
               z = z + ATAN_Q16[k];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - ATAN_Q16[k];
            end
         end
         if (z < 0) z = 0;
         z = (z + 2) >>> 2;
         if (z > longint'(HALF_PI_Q14)) z = longint'(HALF_PI_Q14);
         tab[i] = 16'(z);
      end
      return tab;
   endfunction

endpackage

// ===== hdl/hara_req_if.sv =====
interface hara_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] left_x;
   logic [15:0] left_y;
   logic [15:0] right_x;
   logic [15:0] right_y;
   logic [15:0] dip;

   modport source (output valid, left_x, left_y, right_x, right_y, dip, input ready);
   modport sink (input valid, left_x, left_y, right_x, right_y, dip, output ready);
endinterface

// ===== hdl/hara_rsp_if.sv =====
interface hara_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] angle;
   logic        angle_valid;
   logic [15:0] rphi_sigma;
   logic [15:0] z_sigma;

   modport source (output valid, angle, angle_valid, rphi_sigma, z_sigma, input ready);
   modport sink (input valid, angle, angle_valid, rphi_sigma, z_sigma, output ready);
endinterface

// ===== hdl/hit_angle_and_resolution.sv =====
// One transaction is accepted per cycle unless rsp_ch stalls; the square root and divider
// pipelines take one bit per stage, so depth is set by those two units.
// A stall on rsp_ch freezes every stage at once and nothing is lost.
// Reset clears all stage valid bits and selects the polynomial model.
module hit_angle_and_resolution (
   input  logic       clock,
   input  logic       reset,
   hara_req_if.sink   req_ch,
   hara_rsp_if.source rsp_ch,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   localparam int LAST = 61;
   localparam int SQ_END = 5 + hara_pkg::SQRT_STEPS;
   localparam int DV_END = SQ_END + 2 + hara_pkg::DIV_STEPS;
   localparam hara_pkg::acos_rom_type ACOS_ROM = hara_pkg::acos_rom_build();

   logic advance;
   logic sigma_model_ff;
   logic vld_ff [1:LAST];
   hara_pkg::side_type side_ff [5:LAST-1];

   function automatic logic [4:0] norm_shift(input logic [33:0] m);
      logic [4:0] s;
      s = '0;
      for (int p = 0; p < 34; p++) begin
         if (m[p]) s = 5'((61 - p) >> 1);
      end
      return s;
   endfunction

   assign advance = !vld_ff[LAST] || rsp_ch.ready;
   assign req_ch.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_model_ff <= 1'b1;
      end else if (csr_write_enable) begin
         sigma_model_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= LAST; k++) vld_ff[k] <= 1'b0;
      end else if (advance) begin
         vld_ff[1] <= req_ch.valid;
         for (int k = 2; k <= LAST; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   logic signed [16:0] xt_ff, yt_ff;
   logic signed [15:0] xm_ff, ym_ff;
   logic [15:0] dip_a_ff, dip_b_ff, dip_c_ff, dip_d_ff;
   logic signed [33:0] pxx_ff, pyy_ff;
   logic signed [31:0] pmx_ff, pmy_ff;
   logic signed [32:0] pdx_ff, pdy_ff;
   logic [33:0] tmag_c_ff, tmag_d_ff;
   logic [31:0] mmag_c_ff, mmag_d_ff;
   logic signed [34:0] dot_c_ff, dot_d_ff;
   logic [4:0] s_ff, r_ff;
   logic [61:0] tnorm_ff, mnorm_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         xt_ff <= {req_ch.left_x[15], req_ch.left_x} - {req_ch.right_x[15], req_ch.right_x};
         yt_ff <= {req_ch.left_y[15], req_ch.left_y} - {req_ch.right_y[15], req_ch.right_y};
         xm_ff <= req_ch.right_x;
         ym_ff <= req_ch.right_y;
         dip_a_ff <= req_ch.dip;

         pxx_ff <= xt_ff * xt_ff;
         pyy_ff <= yt_ff * yt_ff;
         pmx_ff <= xm_ff * xm_ff;
         pmy_ff <= ym_ff * ym_ff;
         pdx_ff <= 33'(xt_ff * 33'(xm_ff));
         pdy_ff <= 33'(yt_ff * 33'(ym_ff));
         dip_b_ff <= dip_a_ff;

         tmag_c_ff <= 34'(pxx_ff) + 34'(pyy_ff);
         mmag_c_ff <= 32'(pmx_ff) + 32'(pmy_ff);
         dot_c_ff <= 35'(pdx_ff) + 35'(pdy_ff);
         dip_c_ff <= dip_b_ff;

         tmag_d_ff <= tmag_c_ff;
         mmag_d_ff <= mmag_c_ff;
         dot_d_ff <= dot_c_ff;
         s_ff <= norm_shift(tmag_c_ff);
         r_ff <= norm_shift({2'b00, mmag_c_ff});
         dip_d_ff <= dip_c_ff;

         tnorm_ff <= 62'(tmag_d_ff) << {s_ff, 1'b0};
         mnorm_ff <= 62'(mmag_d_ff) << {r_ff, 1'b0};
         side_ff[5].ok <= (tmag_d_ff != '0) && (mmag_d_ff != '0);
         side_ff[5].neg <= dot_d_ff[34];
         side_ff[5].dip <= dip_d_ff;
         side_ff[5].ad <= dot_d_ff[34] ? 35'(-dot_d_ff) : 35'(dot_d_ff);
         side_ff[5].nsh <= 6'(s_ff) + 6'(r_ff);

         for (int k = 6; k <= LAST - 1; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   logic [30:0] tn, mn;

   hara_sqrt u_sqrt_t (
      .clock   (clock),
      .advance (advance),
      .value   (tnorm_ff),
      .root    (tn)
   );

   hara_sqrt u_sqrt_m (
      .clock   (clock),
      .advance (advance),
      .value   (mnorm_ff),
      .root    (mn)
   );

   logic [61:0] prod_ff;
   logic [63:0] num_m_ff, num_f_ff;
   logic [47:0] den_ff;
   logic [15:0] quo;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= 62'(tn) * 62'(mn);
         num_m_ff <= 64'(side_ff[SQ_END].ad) << side_ff[SQ_END].nsh;
         den_ff <= prod_ff[61:14];
         num_f_ff <= num_m_ff;
      end
   end

   hara_div u_div (
      .clock   (clock),
      .advance (advance),
      .num     (num_f_ff),
      .den     (den_ff),
      .quo     (quo)
   );

   logic [15:0] cos_c;
   logic [15+hara_pkg::IDX_W:0] pos;
   logic [hara_pkg::IDX_W-1:0] idx_w;
   logic [hara_pkg::IDX_W-1:0] idx0_ff, idx1_ff;
   logic [13:0] frac_i_ff, frac_r_ff;
   logic [15:0] t0_ff, t1_ff;
   logic [15:0] a_ff;
   logic [15:0] angle_ff;
   logic [29:0] interp_prod;
   logic [30:0] interp_sum;
   logic [15:0] interp_a;

   assign cos_c = (quo > hara_pkg::COS_ONE_Q14) ? hara_pkg::COS_ONE_Q14 : quo;
   assign pos = (16 + hara_pkg::IDX_W)'(cos_c) * (16 + hara_pkg::IDX_W)'(hara_pkg::ACOS_TABLE_DEPTH);
   assign idx_w = pos[13 + hara_pkg::IDX_W:14];

   assign interp_prod = (t0_ff >= t1_ff) ? 30'(16'(t0_ff - t1_ff)) * 30'(frac_r_ff)
                                         : 30'(16'(t1_ff - t0_ff)) * 30'(frac_r_ff);
   assign interp_sum = 31'(interp_prod) + 31'd8192;
   assign interp_a = (t0_ff >= t1_ff) ? t0_ff - interp_sum[29:14] : t0_ff + interp_sum[29:14];

   always_ff @(posedge clock) begin
      if (advance) begin
         idx0_ff <= idx_w;
         idx1_ff <= (idx_w == hara_pkg::IDX_W'(hara_pkg::ACOS_TABLE_DEPTH)) ? idx_w
                                                                          : idx_w + 1'b1;
         frac_i_ff <= pos[13:0];

         t0_ff <= ACOS_ROM[idx0_ff];
         t1_ff <= ACOS_ROM[idx1_ff];
         frac_r_ff <= frac_i_ff;

         a_ff <= interp_a;

         if (!side_ff[DV_END+3].ok) begin
            angle_ff <= '0;
         end else if (side_ff[DV_END+3].neg) begin
            angle_ff <= hara_pkg::PI_Q14 - a_ff;
         end else begin
            angle_ff <= a_ff;
         end
      end
   end

   logic [15:0] th_ff;
   logic [31:0] thsq_ff;
   logic [21:0] deg1_ff, deg2_ff;
   logic [15:0] absdip_ff;
   logic [48:0] zq_ff;
   logic [30:0] zl_ff;
   logic [49:0] pq_ff;
   logic [32:0] pl_ff;
   logic [39:0] rd_ff;
   logic [38:0] zd_ff;
   logic [15:0] angle1_ff, angle2_ff;
   logic [37:0] deg_prod;
   logic [16:0] dip_ext;
   logic [51:0] z_sum, p_sum;
   logic [40:0] rp_sum;
   logic [39:0] zp_sum;
   logic [15:0] rphi_sel, zs_sel;
   hara_pkg::side_type side_p1;

   assign side_p1 = side_ff[DV_END+4];
   assign deg_prod = 38'(angle_ff) * 38'd3754936 + 38'd32768;
   assign dip_ext = {side_p1.dip[15], side_p1.dip};

   always_ff @(posedge clock) begin
      if (advance) begin
         th_ff <= side_p1.ok ? angle_ff : hara_pkg::HALF_PI_Q14;
         thsq_ff <= side_p1.ok ? 32'(angle_ff) * 32'(angle_ff)
                               : 32'(hara_pkg::HALF_PI_Q14) * 32'(hara_pkg::HALF_PI_Q14);
         deg1_ff <= deg_prod[37:16];
         absdip_ff <= dip_ext[16] ? 16'(-dip_ext) : 16'(dip_ext);
         angle1_ff <= angle_ff;

         zq_ff <= 49'd73400 * 49'(thsq_ff);
         zl_ff <= 31'd31457 * 31'(th_ff);
         pq_ff <= 50'd209715 * 50'(thsq_ff);
         pl_ff <= 33'd104858 * 33'(th_ff);
         rd_ff <= 40'd137405 * 40'(deg1_ff);
         zd_ff <= 39'd5033165 * 39'(absdip_ff);
         deg2_ff <= deg1_ff;
         angle2_ff <= angle1_ff;
      end
   end

   assign z_sum = (52'd293601 << 28) + (52'(zl_ff) << 14) + 52'(zq_ff) + (52'd1 << 35);
   assign p_sum = (52'd387973 << 28) + (52'(pl_ff) << 14) + 52'(pq_ff) + (52'd1 << 35);
   assign rp_sum = (41'd1533449 << 14) + 41'(rd_ff) + (41'd1 << 25);
   assign zp_sum = (40'd3523215 << 12) + 40'(zd_ff) + (40'd1 << 23);

   always_comb begin
      if (sigma_model_ff) begin
         zs_sel = z_sum[51:36];
         rphi_sel = p_sum[51:36];
      end else if (!side_ff[LAST-1].ok) begin
         zs_sel = 16'd2335;
         rphi_sel = 16'd4751;
      end else begin
         zs_sel = zp_sum[39:24];
         if (deg2_ff < (22'd25 << 14)) begin
            rphi_sel = 16'd1229;
         end else if (deg2_ff < (22'd65 << 14)) begin
            rphi_sel = {1'b0, rp_sum[40:26]};
         end else begin
            rphi_sel = 16'd2458;
         end
      end
   end

   logic [15:0] out_angle_ff, out_rphi_ff, out_z_ff;
   logic out_ok_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         out_angle_ff <= angle2_ff;
         out_ok_ff <= side_ff[LAST-1].ok;
         out_rphi_ff <= rphi_sel;
         out_z_ff <= zs_sel;
      end
   end

   assign rsp_ch.valid = vld_ff[LAST];
   assign rsp_ch.angle = out_angle_ff;
   assign rsp_ch.angle_valid = out_ok_ff;
   assign rsp_ch.rphi_sigma = out_rphi_ff;
   assign rsp_ch.z_sigma = out_z_ff;

endmodule

// ===== hdl/hara_sqrt.sv =====
module hara_sqrt (
   input  logic        clock,
   input  logic        advance,
   input  logic [61:0] value,
   output logic [30:0] root
);

   logic [62:0] v_ff [0:hara_pkg::SQRT_STEPS-1];
   logic [62:0] r_ff [0:hara_pkg::SQRT_STEPS-1];

   for (genvar i = 0; i < hara_pkg::SQRT_STEPS; i++) begin : g_step
      logic [62:0] v_prev;
      logic [62:0] r_prev;
      logic [62:0] bit_w;
      logic [62:0] trial;

      if (i == 0) begin : g_first
         assign v_prev = {1'b0, value};
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[i-1];
         assign r_prev = r_ff[i-1];
      end

      assign bit_w = 63'd1 << (60 - 2 * i);
      assign trial = r_prev + bit_w;

      always_ff @(posedge clock) begin
         if (advance) begin
            if (v_prev >= trial) begin
               v_ff[i] <= v_prev - trial;
               r_ff[i] <= (r_prev >> 1) + bit_w;
            end else begin
               v_ff[i] <= v_prev;
               r_ff[i] <= r_prev >> 1;
            end
         end
      end
   end

   assign root = r_ff[hara_pkg::SQRT_STEPS-1][30:0];

endmodule

// ===== hdl/hara_div.sv =====
module hara_div (
   input  logic        clock,
   input  logic        advance,
   input  logic [63:0] num,
   input  logic [47:0] den,
   output logic [15:0] quo
);

   logic [63:0] rem_ff [0:hara_pkg::DIV_STEPS-1];
   logic [47:0] den_ff [0:hara_pkg::DIV_STEPS-1];
   logic [15:0] q_ff   [0:hara_pkg::DIV_STEPS-1];

   for (genvar i = 0; i < hara_pkg::DIV_STEPS; i++) begin : g_step
      logic [63:0] rem_prev;
      logic [47:0] den_prev;
      logic [15:0] q_prev;
      logic [63:0] shifted;

      if (i == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign q_prev   = q_ff[i-1];
      end

      assign shifted = 64'(den_prev) << (hara_pkg::DIV_STEPS - 1 - i);

      always_ff @(posedge clock) begin
         if (advance) begin
            den_ff[i] <= den_prev;
            if (rem_prev >= shifted) begin
               rem_ff[i] <= rem_prev - shifted;
               q_ff[i]   <= {q_prev[14:0], 1'b1};
            end else begin
               rem_ff[i] <= rem_prev;
               q_ff[i]   <= {q_prev[14:0], 1'b0};
            end
         end
      end
   end

   assign quo = q_ff[hara_pkg::DIV_STEPS-1];

endmodule

// ===== verif/hara_checker.sv =====
`timescale 1ns / 100ps

module hara_checker (
   input  logic       clock,
   input  logic       reset,
   hara_req_if        req_ch,
   hara_rsp_if        rsp_ch,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   output int         fail_count,
   output int         pending_count
);

   typedef struct packed {
      logic [15:0] angle;
      logic        angle_valid;
      logic [15:0] rphi_sigma;
      logic [15:0] z_sigma;
   } sigma_result_type;

   sigma_result_type expected_results[$];
   logic [15:0] acos_lut [0:hara_pkg::ACOS_TABLE_DEPTH];
   logic poly_model;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void fill_lut();
      longint unsigned ux;
      longint x, y, z, dx, dy;
      for (int i = 0; i <= hara_pkg::ACOS_TABLE_DEPTH; i++) begin
         ux = (64'(i) << 30) / hara_pkg::ACOS_TABLE_DEPTH;
         x = longint'(ux);
         y = longint'(int_sqrt((64'd1 << 60) - ux * ux));
         z = 0;
         for (int k = 0; k < hara_pkg::CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
               x = x + dx; y = y - dy; z = z + hara_pkg::ATAN_Q16[k];
            end else begin
               x = x - dx; y = y + dy; z = z - hara_pkg::ATAN_Q16[k];
            end
         end
         if (z < 0) z = 0;
         z = (z + 2) >>> 2;
         if (z > 25736) z = 25736;
         acos_lut[i] = 16'(z);
      end
   endfunction

   function automatic longint unsigned scaled_len(longint unsigned m2, output int sh);
      sh = 0;
      while (m2 < (64'd1 << 60)) begin
         m2 = m2 << 2;
         sh++;
      end
      return int_sqrt(m2);
   endfunction

   function automatic sigma_result_type hit_sigma(logic [15:0] lx_b, logic [15:0] ly_b,
         logic [15:0] rx_b, logic [15:0] ry_b, logic [15:0] dip_b, logic use_poly);
      sigma_result_type res;
      longint lx, ly, xm, ym, xt, yt, dip, dot;
      longint unsigned t2, m2, tn, mn, ad, c, pos, idx, frac, a, t0, t1, th, z, p, deg;
      longint unsigned ang, zs, rphi;
      int s, r;
      logic ok, neg;
      lx = longint'($signed(lx_b)); ly = longint'($signed(ly_b));
      xm = longint'($signed(rx_b)); ym = longint'($signed(ry_b));
      dip = longint'($signed(dip_b));
      xt = lx - xm; yt = ly - ym;
      t2 = xt * xt + yt * yt;
      m2 = xm * xm + ym * ym;
      ang = 0;
      ok = 1'b0;
      if (t2 != 0 && m2 != 0) begin
         tn = scaled_len(t2, s);
         mn = scaled_len(m2, r);
         dot = xt * xm + yt * ym;
         neg = dot < 0;
         ad = neg ? -dot : dot;
         c = (ad << (s + r)) / ((tn * mn) >> 14);
         if (c > 16384) c = 16384;
         pos = c * hara_pkg::ACOS_TABLE_DEPTH;
         idx = pos >> 14;
         frac = pos & 16383;
         if (idx >= hara_pkg::ACOS_TABLE_DEPTH) begin
            a = acos_lut[hara_pkg::ACOS_TABLE_DEPTH];
         end else begin
            t0 = acos_lut[idx];
            t1 = acos_lut[idx + 1];
            if (t0 >= t1) a = t0 - (((t0 - t1) * frac + 8192) >> 14);
            else a = t0 + (((t1 - t0) * frac + 8192) >> 14);
         end
         ang = neg ? 51472 - a : a;
         ok = 1'b1;
      end
      if (use_poly) begin
         th = ok ? ang : 25736;
         z = (64'd293601 << 28) + ((64'd31457 * th) << 14) + 64'd73400 * th * th;
         p = (64'd387973 << 28) + ((64'd104858 * th) << 14) + 64'd209715 * th * th;
         zs = (z + (64'd1 << 35)) >> 36;
         rphi = (p + (64'd1 << 35)) >> 36;
      end else if (!ok) begin
         zs = 2335;
         rphi = 4751;
      end else begin
         deg = (ang * 64'd3754936 + 32768) >> 16;
         ad = dip < 0 ? -dip : dip;
         if (deg < (64'd25 << 14)) rphi = 1229;
         else if (deg < (64'd65 << 14))
            rphi = ((64'd1533449 << 14) + 64'd137405 * deg + (64'd1 << 25)) >> 26;
         else rphi = 2458;
         zs = ((64'd3523215 << 12) + 64'd5033165 * ad + (64'd1 << 23)) >> 24;
      end
      res.angle = 16'(ang);
      res.angle_valid = ok;
      res.rphi_sigma = rphi > 65535 ? 16'hFFFF : 16'(rphi);
      res.z_sigma = zs > 65535 ? 16'hFFFF : 16'(zs);
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      fill_lut();
   end

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      sigma_result_type want;
      if (reset) begin
         poly_model <= 1'b1;
         expected_results.delete();
      end else begin
         if (csr_write_enable) poly_model <= csr_write_data;
         if (req_ch.valid && req_ch.ready)
            expected_results.push_back(hit_sigma(req_ch.left_x, req_ch.left_y,
               req_ch.right_x, req_ch.right_y, req_ch.dip, poly_model));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.angle !== want.angle)
                  report_mismatch("angle", int'(rsp_ch.angle), int'(want.angle));
               if (rsp_ch.angle_valid !== want.angle_valid)
                  report_mismatch("angle_valid", int'(rsp_ch.angle_valid),
                     int'(want.angle_valid));
               if (rsp_ch.rphi_sigma !== want.rphi_sigma)
                  report_mismatch("rphi_sigma", int'(rsp_ch.rphi_sigma),
                     int'(want.rphi_sigma));
               if (rsp_ch.z_sigma !== want.z_sigma)
                  report_mismatch("z_sigma", int'(rsp_ch.z_sigma), int'(want.z_sigma));
            end
         end
      end
   end
endmodule

// ===== verif/hit_angle_and_resolution_tb.sv =====
`timescale 1ns / 100ps

module hit_angle_and_resolution_tb;
   localparam int LATENCY = 61;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;
   logic quiet = 1'b0;
   int fail_count, pending_count, idle_cycles;

   hara_req_if req_ch();
   hara_rsp_if rsp_ch();

   hit_angle_and_resolution uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   hara_checker checker_inst (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.left_x = '0; req_ch.left_y = '0;
      req_ch.right_x = '0; req_ch.right_y = '0; req_ch.dip = '0;
      rsp_ch.ready = 1'b0;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_hit(logic [15:0] lx, logic [15:0] ly, logic [15:0] rx,
         logic [15:0] ry, logic [15:0] dp);
      if (!quiet && $urandom_range(5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.left_x <= lx; req_ch.left_y <= ly;
      req_ch.right_x <= rx; req_ch.right_y <= ry; req_ch.dip <= dp;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_model(logic value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic directed_hits();
      send_hit(16'h0100, 16'h0000, 16'h0100, 16'h0000, 16'h1000);
      send_hit(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_hit(16'h0200, 16'h0000, 16'h0100, 16'h0000, 16'h8000);
      send_hit(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h7FFF);
      send_hit(16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'hF000);
      send_hit(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
      send_hit(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_hit(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF);
      send_hit(16'h0300, 16'h0100, 16'h0100, 16'h0000, 16'h0001);
      send_hit(16'h0100, 16'h0400, 16'h0100, 16'h0000, 16'h2000);
      send_hit(16'h0000, 16'h0300, 16'h0100, 16'h0000, 16'hC000);
      send_hit(16'h0001, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
   endtask

   task automatic random_hits(int count);
      logic [15:0] rx, ry, dx, dy;
      for (int n = 0; n < count; n++) begin
         rx = 16'($urandom); ry = 16'($urandom);
         case ($urandom_range(4))
            0: begin dx = 16'($urandom); dy = 16'($urandom); end
            1: begin dx = 16'($signed(rx) >>> $urandom_range(6)); dy = 16'($signed(ry) >>> $urandom_range(6)); end
            2: begin dx = 16'($urandom_range(511)) - 16'd256; dy = 16'($urandom_range(511)) - 16'd256; end
            3: begin dx = 16'(-$signed(ry) >>> 2); dy = 16'($signed(rx) >>> 2); end
            default: begin dx = $urandom_range(1) ? 16'd0 : 16'($urandom_range(3)); dy = '0; end
         endcase
         if ($urandom_range(30) == 0) begin rx = '0; ry = '0; end
         send_hit(rx + dx, ry + dy, rx, ry, 16'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      directed_hits();
      drain();
      write_model(1'b0);
      directed_hits();
      random_hits(400);
      drain();
      write_model(1'b1);
      random_hits(400);
      drain();
      write_model(1'b0);
      random_hits(450);
      drain();
      write_model(1'b1);
      random_hits(250);
      quiet <= 1'b1;
      random_hits(250);
      drain();
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
hdl/hara_pkg.sv
hdl/hara_req_if.sv
hdl/hara_rsp_if.sv
hdl/hara_sqrt.sv
hdl/hara_div.sv
hdl/hit_angle_and_resolution.sv
verif/hara_checker.sv
verif/hit_angle_and_resolution_tb.sv
